[design/srde_pkg.sv]
// Shared types and constants for the signed radix digit emitter.
// Depends on nothing; every other design file imports it.
`default_nettype none

package srde_pkg;

	localparam int MAX_BASE    = 16;
	localparam int DIGIT_SLOTS = 32;
	localparam int NUM_W       = 32;
	localparam int CHAR_W      = 8;
	localparam int DIG_W       = $clog2(MAX_BASE);
	localparam int CNT_W       = $clog2(MAX_BASE + 1);
	localparam int SLOT_W      = $clog2(DIGIT_SLOTS + 1);
	localparam int STEP_W      = $clog2(NUM_W);

	// Request opcodes
	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_APPEND  = 2'd1;
	localparam logic [1:0] OP_CONVERT = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

	typedef struct packed {
		logic [1:0]              opcode;
		logic [CHAR_W-1:0]       symbol;
		logic signed [NUM_W-1:0] number;
	} req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic clear;
		logic append;
	} alpha_ctrl_t;

	typedef struct packed {
		logic start;
		logic next;
	} div_ctrl_t;

	typedef struct packed {
		logic done;
		logic quot_zero;
	} div_stat_t;

	typedef struct packed {
		logic push;
		logic pop;
	} stack_ctrl_t;

endpackage

`default_nettype wire

[design/srde_alpha.sv]
// Digit alphabet store: clear, checked append, and the symbol lookup for emission.
// Depends on srde_pkg.
`default_nettype none

module srde_alpha
	import srde_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire alpha_ctrl_t       ctrl,
	input  wire logic [CHAR_W-1:0] symbol,
	input  wire logic [DIG_W-1:0]  rd_idx,
	output logic [CHAR_W-1:0]      rd_char,
	output logic [CNT_W-1:0]       count,
	output logic                   bad
);

	logic [CHAR_W-1:0] symbols_q [MAX_BASE];
	logic [CNT_W-1:0]  count_q;
	logic              bad_q;
	logic [MAX_BASE-1:0] hit;
	logic              is_sign;
	logic              is_full;
	logic              reject;

	// Compare the new symbol against every stored entry in parallel
	always_comb begin
		for (int k = 0; k < MAX_BASE; k++) begin
			hit[k] = (CNT_W'(k) < count_q) && (symbols_q[k] == symbol);
		end
	end

	assign is_sign = (symbol == CHAR_MINUS) || (symbol == CHAR_PLUS);
	assign is_full = (count_q >= CNT_W'(MAX_BASE));
	assign reject  = is_sign || (|hit) || is_full;

	// Hold count and error flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bad_q   <= 1'b0;
		end else if (ctrl.clear) begin
			count_q <= '0;
			bad_q   <= 1'b0;
		end else if (ctrl.append) begin
			if (reject) begin
				bad_q <= 1'b1;
			end else begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Store accepted symbols
	always_ff @(posedge clk) begin
		if (ctrl.append && !ctrl.clear && !reject) begin
			symbols_q[count_q[DIG_W-1:0]] <= symbol;
		end
	end

	assign rd_char = symbols_q[rd_idx];
	assign count   = count_q;
	assign bad     = bad_q;

endmodule

`default_nettype wire

[design/srde_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, remainder is one digit.
// Depends on srde_pkg.
`default_nettype none

module srde_div
	import srde_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_ctrl_t        ctrl,
	input  wire logic [NUM_W-1:0] dividend,
	input  wire logic [CNT_W-1:0] base,
	output div_stat_t             stat,
	output logic [DIG_W-1:0]      digit
);

	logic [NUM_W-1:0]  quot_q;
	logic [DIG_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  trial;
	logic              fits;

	// Shift the next dividend bit into the partial remainder
	assign trial = {rem_q, quot_q[NUM_W-1]};
	assign fits  = (trial >= base);

	// Sequence the 32 steps of one division
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start || ctrl.next) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Advance quotient and remainder; next division reuses the quotient
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (ctrl.next) begin
			rem_q <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[NUM_W-2:0], fits};
			rem_q  <= fits ? DIG_W'(trial - base) : trial[DIG_W-1:0];
		end
	end

	assign stat.done      = done_q;
	assign stat.quot_zero = (quot_q == '0);
	assign digit          = rem_q;

endmodule

`default_nettype wire

[design/srde_stack.sv]
// Digit stack as a shift line: push at the head, pop from the head.
// Depends on srde_pkg.
`default_nettype none

module srde_stack
	import srde_pkg::*;
(
	input  wire logic             clk,
	input  wire stack_ctrl_t      ctrl,
	input  wire logic [DIG_W-1:0] push_digit,
	output logic [DIG_W-1:0]      top_digit
);

	logic [DIG_W-1:0] slots_q [DIGIT_SLOTS];

	// Shift up on push, down on pop
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			slots_q[0] <= push_digit;
			for (int i = 1; i < DIGIT_SLOTS; i++) begin
				slots_q[i] <= slots_q[i-1];
			end
		end else if (ctrl.pop) begin
			for (int i = 0; i < DIGIT_SLOTS - 1; i++) begin
				slots_q[i] <= slots_q[i+1];
			end
		end
	end

	assign top_digit = slots_q[0];

endmodule

`default_nettype wire

[design/signed_radix_digit_emitter.sv]
// Signed radix digit emitter. Clear and append requests update the digit
// alphabet. A convert request with a valid alphabet of B >= 2 symbols takes
// the magnitude through a bit-serial divider; once all digits are found it emits
// one character per cycle (plus a leading '-' for a negative number) as fast
// as the consumer takes them; the divider finds one quotient bit per cycle.
// A rejected convert emits nothing.
// Input ready is high only while no conversion is in progress.
// Depends on srde_pkg, srde_alpha, srde_div and srde_stack.
`default_nettype none

module signed_radix_digit_emitter
	import srde_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire req_t in_req,
	output logic      out_valid,
	input  wire logic out_ready,
	output rsp_t      out_rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_EMIT
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] ndig_q;
	logic              neg_q;
	logic              out_valid_q;
	rsp_t              out_q;

	alpha_ctrl_t       alpha_ctrl;
	div_ctrl_t         div_ctrl;
	div_stat_t         div_stat;
	stack_ctrl_t       stack_ctrl;
	logic [CHAR_W-1:0] digit_char;
	logic [CNT_W-1:0]  sym_count;
	logic              alpha_bad;
	logic [DIG_W-1:0]  div_digit;
	logic [DIG_W-1:0]  top_digit;
	logic [NUM_W-1:0]  num_u;
	logic [NUM_W-1:0]  mag;
	logic              accept;
	logic              convert_ok;
	logic              slot_free;

	assign accept     = in_valid && in_ready;
	assign num_u      = NUM_W'(in_req.number);
	assign mag        = num_u[NUM_W-1] ? (~num_u + NUM_W'(1)) : num_u;
	assign convert_ok = (in_req.opcode == OP_CONVERT) && !alpha_bad
		&& (sym_count >= CNT_W'(2));
	assign slot_free  = !out_valid_q || out_ready;

	// Decode requests and sequence divider, stack and output
	always_comb begin
		alpha_ctrl.clear  = accept && (in_req.opcode == OP_CLEAR);
		alpha_ctrl.append = accept && (in_req.opcode == OP_APPEND);
		div_ctrl.start    = accept && convert_ok;
		div_ctrl.next     = (state_q == S_DIV) && div_stat.done && !div_stat.quot_zero;
		stack_ctrl.push   = (state_q == S_DIV) && div_stat.done;
		stack_ctrl.pop    = (state_q == S_EMIT) && slot_free && !neg_q;
	end

	srde_alpha u_alpha (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (alpha_ctrl),
		.symbol  (in_req.symbol),
		.rd_idx  (top_digit),
		.rd_char (digit_char),
		.count   (sym_count),
		.bad     (alpha_bad)
	);

	srde_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (mag),
		.base     (sym_count),
		.stat     (div_stat),
		.digit    (div_digit)
	);

	srde_stack u_stack (
		.clk        (clk),
		.ctrl       (stack_ctrl),
		.push_digit (div_digit),
		.top_digit  (top_digit)
	);

	// State, digit count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ndig_q      <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// Load a new character, or drop the held one once taken
			if ((state_q == S_EMIT) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (div_ctrl.start) begin
						state_q <= S_DIV;
						ndig_q  <= '0;
						neg_q   <= num_u[NUM_W-1];
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						ndig_q <= ndig_q + SLOT_W'(1);
						if (div_stat.quot_zero) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						if (neg_q) begin
							neg_q          <= 1'b0;
							out_q.out_char <= CHAR_MINUS;
							out_q.last     <= 1'b0;
						end else begin
							out_q.out_char <= digit_char;
							out_q.last     <= (ndig_q == SLOT_W'(1));
							ndig_q         <= ndig_q - SLOT_W'(1);
							if (ndig_q == SLOT_W'(1)) begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;

endmodule

`default_nettype wire

[design/srde_check.sv]
// Port-level checks for the signed radix digit emitter, bound to the top level.
// Depends on srde_pkg and signed_radix_digit_emitter.
`default_nettype none

module srde_check
	import srde_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire req_t in_req,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire rsp_t out_rsp
);

	// Hold a stalled character
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_rsp))
		else $error("stalled output character changed or dropped");

	// No new request while a conversion still has characters to send
	a_busy_mid_conv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_rsp.last |-> !in_ready)
		else $error("request accepted in the middle of a conversion");

	// A clear or append accepted with no character pending produces no character
	a_no_char_on_edit: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid
		&& (in_req.opcode == OP_CLEAR || in_req.opcode == OP_APPEND) |=> !out_valid)
		else $error("character emitted after an alphabet edit");

	// A minus sign is never the final character of a conversion
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_rsp.out_char == CHAR_MINUS) |-> !out_rsp.last)
		else $error("minus sign emitted as final character");

endmodule

bind signed_radix_digit_emitter srde_check u_srde_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_req    (in_req),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_rsp   (out_rsp)
);

`default_nettype wire
